### hdl/lefs_pkg.sv
package lefs_pkg;

  // Item kinds carried on the input channel
  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_RUN     = 2'd1,
    KIND_START   = 2'd2,
    KIND_DISABLE = 2'd3
  } kind_t;

  // Motor direction codes
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_IN   = 2'd1;
  localparam logic [1:0] DIR_OUT  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_INNER_LIMIT  = 2'd0;
  localparam logic [1:0] REG_OUTER_LIMIT  = 2'd1;
  localparam logic [1:0] REG_HIGH_CURRENT = 2'd2;
  localparam logic [1:0] REG_LOW_CURRENT  = 2'd3;

  // Configuration reset values
  localparam logic [1:0] INNER_LIMIT_RST  = 2'd1;
  localparam logic [1:0] OUTER_LIMIT_RST  = 2'd2;
  localparam logic [7:0] HIGH_CURRENT_RST = 8'd2;
  localparam logic [7:0] LOW_CURRENT_RST  = 8'd1;

  // Status byte bit positions
  localparam int unsigned ST_FOOT_BIT   = 2;
  localparam int unsigned ST_ANGLE_BIT  = 5;
  localparam int unsigned ST_GROUND_BIT = 6;

  // Sequence steps
  localparam logic [2:0] STEP_ARM     = 3'd0;
  localparam logic [2:0] STEP_EXTEND  = 3'd1;
  localparam logic [2:0] STEP_RETRACT = 3'd2;
  localparam logic [2:0] STEP_FOLLOW  = 3'd3;

  // Timeouts in 100 ms ticks
  localparam logic [5:0] TMO_AT_INNER  = 6'd60;
  localparam logic [5:0] TMO_AWAY      = 6'd30;
  localparam logic [5:0] TMO_FOOT      = 6'd20;
  localparam logic [15:0] FOLLOW_TICKS = 16'd5;

  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

endpackage

### hdl/lefs_in_if.sv
interface lefs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] status;
  logic       leg_power_busy;
  logic [2:0] start_step;

  modport source (output valid, kind, status, leg_power_busy, start_step, input ready);
  modport sink   (input valid, kind, status, leg_power_busy, start_step, output ready);
endinterface

### hdl/lefs_out_if.sv
interface lefs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] direction;
  logic [7:0] current_code;
  logic       enabled;
  logic [2:0] step_now;

  modport source (output valid, direction, current_code, enabled, step_now, input ready);
  modport sink   (input valid, direction, current_code, enabled, step_now, output ready);
endinterface

### hdl/lefs_cfg_if.sv
interface lefs_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/leg_extend_follow_sequencer.sv
// An accepted input beat reaches its result beat through the input register,
//   then the sequencer state, which doubles as the result register.
// Throughput: one beat per cycle; the input register takes a new beat while a
//   result waits, and the two stages advance together when the sink is ready.
// Reset (rst_n low, synchronous): sequencer idle at step 0, motor stopped, timers
//   and current cleared, limit and current codes back to defaults, no beat pending.
module leg_extend_follow_sequencer (
  input  logic              clk,
  input  logic              rst_n,
  lefs_in_if.sink           in_ch,
  lefs_out_if.source        out_ch,
  lefs_cfg_if.sink          cfg_ch
);

  // Configuration registers
  logic [1:0] inner_code_r;
  logic [1:0] outer_code_r;
  logic [7:0] high_cur_r;
  logic [7:0] low_cur_r;

  // Input stage
  logic       s1_valid_r;
  logic [1:0] s1_kind_r;
  logic [7:0] s1_status_r;
  logic       s1_busy_r;
  logic [2:0] s1_start_r;

  // Sequencer state (also the result payload)
  logic        out_valid_r;
  logic        active_r,  active_nxt;
  logic [2:0]  step_r,    step_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [5:0]  timeout_r, timeout_nxt;
  logic [1:0]  dir_r,     dir_nxt;
  logic [7:0]  cur_r,     cur_nxt;

  logic s1_adv;
  logic in_acc;

  assign s1_adv = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_acc = in_ch.valid && in_ch.ready;

  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.direction    = dir_r;
  assign out_ch.current_code = cur_r;
  assign out_ch.enabled      = active_r;
  assign out_ch.step_now     = step_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_code_r <= lefs_pkg::INNER_LIMIT_RST;
      outer_code_r <= lefs_pkg::OUTER_LIMIT_RST;
      high_cur_r   <= lefs_pkg::HIGH_CURRENT_RST;
      low_cur_r    <= lefs_pkg::LOW_CURRENT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        lefs_pkg::REG_INNER_LIMIT:  inner_code_r <= cfg_ch.data[1:0];
        lefs_pkg::REG_OUTER_LIMIT:  outer_code_r <= cfg_ch.data[1:0];
        lefs_pkg::REG_HIGH_CURRENT: high_cur_r   <= cfg_ch.data;
        lefs_pkg::REG_LOW_CURRENT:  low_cur_r    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r   <= in_ch.kind;
      s1_status_r <= in_ch.status;
      s1_busy_r   <= in_ch.leg_power_busy;
      s1_start_r  <= in_ch.start_step;
    end
  end

  // Sequencer next state for the beat in the input register
  always_comb begin
    logic [1:0] lim;
    logic       foot;
    logic       angle;
    logic       ground;
    logic       at_inner;
    logic       at_outer;
    logic [15:0] el_tmp;
    logic [5:0]  to_tmp;

    lim      = s1_status_r[1:0];
    foot     = s1_status_r[lefs_pkg::ST_FOOT_BIT];
    angle    = s1_status_r[lefs_pkg::ST_ANGLE_BIT];
    ground   = s1_status_r[lefs_pkg::ST_GROUND_BIT];
    at_inner = (lim == inner_code_r);
    at_outer = (lim == outer_code_r);

    active_nxt  = active_r;
    step_nxt    = step_r;
    elapsed_nxt = elapsed_r;
    timeout_nxt = timeout_r;
    dir_nxt     = dir_r;
    cur_nxt     = cur_r;
    el_tmp      = elapsed_r;
    to_tmp      = timeout_r;

    case (lefs_pkg::kind_t'(s1_kind_r))
      lefs_pkg::KIND_TICK: begin
        if (elapsed_r != lefs_pkg::ELAPSED_MAX) begin
          elapsed_nxt = elapsed_r + 16'd1;
        end
      end
      lefs_pkg::KIND_RUN: begin
        if (active_r && !s1_busy_r) begin
          case (step_r)
            lefs_pkg::STEP_ARM: begin
              step_nxt    = lefs_pkg::STEP_EXTEND;
              elapsed_nxt = '0;
              timeout_nxt = at_inner ? lefs_pkg::TMO_AT_INNER : lefs_pkg::TMO_AWAY;
            end
            lefs_pkg::STEP_EXTEND: begin
              if (at_outer) begin
                step_nxt = lefs_pkg::STEP_RETRACT;
                dir_nxt  = lefs_pkg::DIR_STOP;
              end else if (ground || angle) begin
                dir_nxt     = lefs_pkg::DIR_STOP;
                step_nxt    = lefs_pkg::STEP_RETRACT;
                elapsed_nxt = '0;
              end else begin
                // foot pressed restarts the shorter timeout
                if (foot) begin
                  to_tmp = lefs_pkg::TMO_FOOT;
                  el_tmp = '0;
                end
                timeout_nxt = to_tmp;
                elapsed_nxt = el_tmp;
                if (el_tmp < {10'd0, to_tmp}) begin
                  cur_nxt = high_cur_r;
                  dir_nxt = lefs_pkg::DIR_OUT;
                end else begin
                  step_nxt    = lefs_pkg::STEP_RETRACT;
                  elapsed_nxt = '0;
                end
              end
            end
            lefs_pkg::STEP_RETRACT: begin
              if (foot) begin
                step_nxt    = lefs_pkg::STEP_FOLLOW;
                elapsed_nxt = '0;
              end else if (at_inner) begin
                active_nxt = 1'b0;
                dir_nxt    = lefs_pkg::DIR_STOP;
              end else if (angle) begin
                dir_nxt = lefs_pkg::DIR_STOP;
              end else begin
                cur_nxt = low_cur_r;
                dir_nxt = lefs_pkg::DIR_IN;
              end
            end
            lefs_pkg::STEP_FOLLOW: begin
              if (elapsed_r > lefs_pkg::FOLLOW_TICKS || at_inner) begin
                active_nxt = 1'b0;
                dir_nxt    = lefs_pkg::DIR_STOP;
              end else if (angle) begin
                dir_nxt = lefs_pkg::DIR_STOP;
              end else begin
                cur_nxt = high_cur_r;
                dir_nxt = lefs_pkg::DIR_IN;
              end
            end
            default: begin
              // steps past the sequence just shut it down
              active_nxt = 1'b0;
              dir_nxt    = lefs_pkg::DIR_STOP;
            end
          endcase
        end
      end
      lefs_pkg::KIND_START: begin
        active_nxt = 1'b1;
        step_nxt   = s1_start_r;
      end
      lefs_pkg::KIND_DISABLE: begin
        active_nxt = 1'b0;
        step_nxt   = lefs_pkg::STEP_ARM;
      end
      default: ;
    endcase
  end

  // Sequencer state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      active_r    <= 1'b0;
      step_r      <= lefs_pkg::STEP_ARM;
      elapsed_r   <= '0;
      timeout_r   <= '0;
      dir_r       <= lefs_pkg::DIR_STOP;
      cur_r       <= '0;
    end else begin
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        active_r    <= active_nxt;
        step_r      <= step_nxt;
        elapsed_r   <= elapsed_nxt;
        timeout_r   <= timeout_nxt;
        dir_r       <= dir_nxt;
        cur_r       <= cur_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

### hdl/lefs_chk.sv
module lefs_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_direction,
  input logic [7:0] out_current_code,
  input logic       out_enabled,
  input logic [2:0] out_step_now
);

  // No result beat right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Direction is only ever stop, in or out
  a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_direction != 2'd3))
    else $error("illegal direction code");

  // A stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_direction) && $stable(out_current_code)
      && $stable(out_enabled) && $stable(out_step_now))
    else $error("result payload changed while stalled");

endmodule

bind leg_extend_follow_sequencer lefs_chk u_lefs_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_direction    (out_ch.direction),
  .out_current_code (out_ch.current_code),
  .out_enabled      (out_ch.enabled),
  .out_step_now     (out_ch.step_now)
);

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int RANDOM_BEATS = 1100;
  localparam int PHASE_BEATS  = 120;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    lefs_pkg::kind_t kind;
    logic [7:0]      status;
    logic            leg_power_busy;
    logic [2:0]      start_step;
  } beat_t;

  typedef struct packed {
    logic [1:0] direction;
    logic [7:0] current_code;
    logic       enabled;
    logic [2:0] step_now;
  } result_t;

  // Tracks the sequencer state and the result beats still owed by the block
  class leg_motion_ledger;
    logic [1:0]  inner_code = lefs_pkg::INNER_LIMIT_RST;
    logic [1:0]  outer_code = lefs_pkg::OUTER_LIMIT_RST;
    logic [7:0]  high_cur   = lefs_pkg::HIGH_CURRENT_RST;
    logic [7:0]  low_cur    = lefs_pkg::LOW_CURRENT_RST;
    bit          active     = 1'b0;
    logic [2:0]  step       = lefs_pkg::STEP_ARM;
    logic [15:0] elapsed    = '0;
    logic [5:0]  timeout    = '0;
    logic [1:0]  dir        = lefs_pkg::DIR_STOP;
    logic [7:0]  cur        = '0;
    result_t     awaited_results[$];
    int          errors     = 0;

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        lefs_pkg::REG_INNER_LIMIT:  inner_code = val[1:0];
        lefs_pkg::REG_OUTER_LIMIT:  outer_code = val[1:0];
        lefs_pkg::REG_HIGH_CURRENT: high_cur = val;
        default:                    low_cur = val;
      endcase
    endfunction

    function void halt_motor();
      active = 1'b0;
      dir = lefs_pkg::DIR_STOP;
    endfunction

    // Retract unless at the inner limit or the angle switch is on
    function void retract(logic [7:0] st, logic [7:0] code);
      if (st[1:0] == inner_code || st[lefs_pkg::ST_ANGLE_BIT]) begin
        dir = lefs_pkg::DIR_STOP;
      end else begin
        cur = code;
        dir = lefs_pkg::DIR_IN;
      end
    endfunction

    function void extend(logic [7:0] st, logic [7:0] code);
      if (st[1:0] == outer_code || st[lefs_pkg::ST_ANGLE_BIT] ||
          st[lefs_pkg::ST_GROUND_BIT]) begin
        dir = lefs_pkg::DIR_STOP;
      end else begin
        cur = code;
        dir = lefs_pkg::DIR_OUT;
      end
    endfunction

    function void advance(logic [7:0] st);
      logic [1:0] lim;
      lim = st[1:0];
      case (step)
        lefs_pkg::STEP_ARM: begin
          step = lefs_pkg::STEP_EXTEND;
          elapsed = '0;
          timeout = (lim == inner_code) ? lefs_pkg::TMO_AT_INNER : lefs_pkg::TMO_AWAY;
        end
        lefs_pkg::STEP_EXTEND: begin
          if (lim == outer_code) begin
            step = lefs_pkg::STEP_RETRACT;
            dir = lefs_pkg::DIR_STOP;
          end else if (st[lefs_pkg::ST_GROUND_BIT] || st[lefs_pkg::ST_ANGLE_BIT]) begin
            dir = lefs_pkg::DIR_STOP;
            step = lefs_pkg::STEP_RETRACT;
            elapsed = '0;
          end else begin
            // foot pressed: shorter timeout, restart the clock
            if (st[lefs_pkg::ST_FOOT_BIT]) begin
              timeout = lefs_pkg::TMO_FOOT;
              elapsed = '0;
            end
            if (elapsed < {10'd0, timeout}) begin
              extend(st, high_cur);
            end else begin
              step = lefs_pkg::STEP_RETRACT;
              elapsed = '0;
            end
          end
        end
        lefs_pkg::STEP_RETRACT: begin
          if (st[lefs_pkg::ST_FOOT_BIT]) begin
            step = lefs_pkg::STEP_FOLLOW;
            elapsed = '0;
          end else if (lim == inner_code) begin
            halt_motor();
          end else begin
            retract(st, low_cur);
          end
        end
        lefs_pkg::STEP_FOLLOW: begin
          if (elapsed > lefs_pkg::FOLLOW_TICKS || lim == inner_code) halt_motor();
          else retract(st, high_cur);
        end
        default: halt_motor();
      endcase
    endfunction

    function void note_beat(beat_t b);
      result_t want;
      case (b.kind)
        lefs_pkg::KIND_TICK: begin
          if (elapsed != lefs_pkg::ELAPSED_MAX) elapsed = elapsed + 16'd1;
        end
        lefs_pkg::KIND_RUN: begin
          if (active && !b.leg_power_busy) advance(b.status);
        end
        lefs_pkg::KIND_START: begin
          active = 1'b1;
          step = b.start_step;
        end
        default: begin
          active = 1'b0;
          step = lefs_pkg::STEP_ARM;
        end
      endcase
      want.direction = dir;
      want.current_code = cur;
      want.enabled = active;
      want.step_now = step;
      awaited_results.push_back(want);
    endfunction

    function void compare(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, %s %0d cur %0d en %0d step %0d",
                 $time, "actual dir", got.direction, got.current_code, got.enabled,
                 got.step_now);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      compare("direction", want.direction, got.direction);
      compare("current_code", want.current_code, got.current_code);
      compare("enabled", want.enabled, got.enabled);
      compare("step_now", want.step_now, got.step_now);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm_phase;
  bit   hold_req;
  int   beats_sent;

  leg_motion_ledger ledger = new;

  lefs_in_if  in_bus ();
  lefs_out_if out_bus ();
  lefs_cfg_if cfg_bus ();

  leg_extend_follow_sequencer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("leg_extend_follow_sequencer: mismatch");
    $finish;
  end

  // Gap length: mostly short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int send_gap();
    if (calm_phase || $urandom_range(0, 99) < 60) return 0;
    return idle_len();
  endfunction

  function automatic beat_t make_beat(lefs_pkg::kind_t k, logic [7:0] st, logic busy,
                                      logic [2:0] start);
    beat_t b;
    b.kind = k;
    b.status = st;
    b.leg_power_busy = busy;
    b.start_step = start;
    return b;
  endfunction

  function automatic beat_t noise_beat();
    return make_beat(lefs_pkg::kind_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                     3'($urandom));
  endfunction

  // A limit code that is neither the inner nor the outer one, if there is one
  function automatic logic [1:0] free_limit();
    logic [1:0] c;
    c = 2'($urandom);
    for (int i = 0; i < 4; i++) begin
      if (c != ledger.inner_code && c != ledger.outer_code) return c;
      c = c + 2'd1;
    end
    return c;
  endfunction

  function automatic logic [7:0] quiet_status();
    logic [7:0] s;
    s = 8'($urandom);
    s[1:0] = free_limit();
    s[lefs_pkg::ST_ANGLE_BIT] = 1'b0;
    s[lefs_pkg::ST_GROUND_BIT] = 1'b0;
    s[lefs_pkg::ST_FOOT_BIT] = ($urandom_range(0, 99) < 8);
    return s;
  endfunction

  // Offer one input beat and wait for it to be taken
  task automatic push_beat(input beat_t b);
    int gap;
    gap = send_gap();
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.kind = b.kind;
    in_bus.status = b.status;
    in_bus.leg_power_busy = b.leg_power_busy;
    in_bus.start_step = b.start_step;
    do @(posedge clk); while (!in_bus.ready);
    ledger.note_beat(b);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data = val;
    do @(posedge clk); while (!cfg_bus.ready);
    ledger.set_reg(idx, val);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // Drain all owed results, then let the pipeline settle
  task automatic settle();
    in_bus.valid = 1'b0;
    while (ledger.awaited_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Start a sequence and mostly feed it ticks and clean run steps
  task automatic run_sequence();
    int n;
    int r;
    logic [7:0] st;
    n = 0;
    push_beat(make_beat(lefs_pkg::KIND_START, 8'($urandom), 1'($urandom),
                        ($urandom_range(0, 99) < 80) ? lefs_pkg::STEP_ARM : 3'($urandom)));
    while (ledger.active && n < 160) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        push_beat(make_beat(lefs_pkg::KIND_TICK, 8'($urandom), 1'($urandom), 3'($urandom)));
      end else if (r < 96) begin
        st = ($urandom_range(0, 99) < 88) ? quiet_status() : 8'($urandom);
        push_beat(make_beat(lefs_pkg::KIND_RUN, st, ($urandom_range(0, 99) < 5),
                            3'($urandom)));
      end else if (r < 98) begin
        push_beat(make_beat(lefs_pkg::KIND_DISABLE, 8'($urandom), 1'($urandom),
                            3'($urandom)));
      end else begin
        push_beat(make_beat(lefs_pkg::KIND_START, 8'($urandom), 1'($urandom),
                            3'($urandom)));
      end
      n++;
    end
  endtask

  // Result side ready: random stalls, calm stretches, one long hold-off
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_bus.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (stall_left > 0) begin
        out_bus.ready = 1'b0;
        stall_left--;
      end else if (!calm_phase && $urandom_range(0, 99) < 25) begin
        out_bus.ready = 1'b0;
        stall_left = idle_len() - 1;
      end else begin
        out_bus.ready = 1'b1;
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin : result_monitor
    result_t got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.direction = out_bus.direction;
      got.current_code = out_bus.current_code;
      got.enabled = out_bus.enabled;
      got.step_now = out_bus.step_now;
      ledger.check_result(got);
    end
  end

  initial begin : stimulus
    int phase_no;
    int phase_start;
    int random_start;
    int drain;
    rst_n = 1'b0;
    calm_phase = 1'b0;
    hold_req = 1'b0;
    beats_sent = 0;
    in_bus.valid = 1'b0;
    in_bus.kind = lefs_pkg::KIND_TICK;
    in_bus.status = '0;
    in_bus.leg_power_busy = 1'b0;
    in_bus.start_step = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = lefs_pkg::REG_INNER_LIMIT;
    cfg_bus.data = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: idle items, every step and its exits, at reset settings
    push_beat(make_beat(lefs_pkg::KIND_DISABLE, 8'hFF, 1'b1, 3'd7));
    push_beat(make_beat(lefs_pkg::KIND_TICK, 8'hFF, 1'b1, 3'd7));
    push_beat(make_beat(lefs_pkg::KIND_RUN, 8'h00, 1'b0, 3'd0));
    push_beat(make_beat(lefs_pkg::KIND_START, 8'h00, 1'b0, lefs_pkg::STEP_ARM));
    push_beat(make_beat(lefs_pkg::KIND_RUN, 8'h01, 1'b0, 3'd0));   // arm at inner limit
    push_beat(make_beat(lefs_pkg::KIND_RUN, 8'h00, 1'b1, 3'd0));   // other leg busy
    push_beat(make_beat(lefs_pkg::KIND_RUN, 8'h98, 1'b0, 3'd0));   // extend
    push_beat(make_beat(lefs_pkg::KIND_RUN, 8'h04, 1'b0, 3'd0));   // foot while extending
    push_beat(make_beat(lefs_pkg::KIND_RUN, 8'h23, 1'b0, 3'd0));   // angle ends extend
    push_beat(make_beat(lefs_pkg::KIND_RUN, 8'h00, 1'b0, 3'd0));   // retract
    push_beat(make_beat(lefs_pkg::KIND_RUN, 8'h20, 1'b0, 3'd0));   // angle stops retract
    push_beat(make_beat(lefs_pkg::KIND_RUN, 8'h04, 1'b0, 3'd0));   // foot: follow
    push_beat(make_beat(lefs_pkg::KIND_RUN, 8'h00, 1'b0, 3'd0));
    repeat (6) push_beat(make_beat(lefs_pkg::KIND_TICK, 8'h00, 1'b0, 3'd0));
    push_beat(make_beat(lefs_pkg::KIND_RUN, 8'h00, 1'b0, 3'd0));   // follow time over
    push_beat(make_beat(lefs_pkg::KIND_START, 8'hFF, 1'b1, lefs_pkg::STEP_EXTEND));
    push_beat(make_beat(lefs_pkg::KIND_RUN, 8'h02, 1'b0, 3'd7));   // outer limit
    push_beat(make_beat(lefs_pkg::KIND_RUN, 8'h01, 1'b0, 3'd0));   // retract reaches inner
    push_beat(make_beat(lefs_pkg::KIND_START, 8'h00, 1'b0, lefs_pkg::STEP_FOLLOW));
    push_beat(make_beat(lefs_pkg::KIND_RUN, 8'h01, 1'b0, 3'd0));   // follow at inner limit
    push_beat(make_beat(lefs_pkg::KIND_START, 8'h00, 1'b0, 3'd7));
    push_beat(make_beat(lefs_pkg::KIND_RUN, 8'h00, 1'b0, 3'd0));   // step out of range
    push_beat(make_beat(lefs_pkg::KIND_START, 8'h00, 1'b0, lefs_pkg::STEP_ARM));
    push_beat(make_beat(lefs_pkg::KIND_RUN, 8'h00, 1'b0, 3'd0));   // arm away from inner
    push_beat(make_beat(lefs_pkg::KIND_RUN, 8'h40, 1'b0, 3'd0));   // ground ends extend
    push_beat(make_beat(lefs_pkg::KIND_START, 8'h00, 1'b0, lefs_pkg::STEP_ARM));
    push_beat(make_beat(lefs_pkg::KIND_RUN, 8'h00, 1'b0, 3'd0));
    repeat (30) push_beat(make_beat(lefs_pkg::KIND_TICK, 8'h00, 1'b0, 3'd0));
    push_beat(make_beat(lefs_pkg::KIND_RUN, 8'h00, 1'b0, 3'd0));   // extend times out

    // Random phases, each under new settings
    phase_no = 0;
    random_start = beats_sent;
    while (beats_sent - random_start < RANDOM_BEATS) begin
      settle();
      case (phase_no)
        0: begin
          write_reg(lefs_pkg::REG_INNER_LIMIT, 8'd0);
          write_reg(lefs_pkg::REG_OUTER_LIMIT, 8'd0);
          write_reg(lefs_pkg::REG_HIGH_CURRENT, 8'd0);
          write_reg(lefs_pkg::REG_LOW_CURRENT, 8'd0);
        end
        1: begin
          write_reg(lefs_pkg::REG_INNER_LIMIT, 8'd3);
          write_reg(lefs_pkg::REG_OUTER_LIMIT, 8'd3);
          write_reg(lefs_pkg::REG_HIGH_CURRENT, 8'hFF);
          write_reg(lefs_pkg::REG_LOW_CURRENT, 8'hFF);
        end
        2: begin
          write_reg(lefs_pkg::REG_INNER_LIMIT, {6'd0, lefs_pkg::INNER_LIMIT_RST});
          write_reg(lefs_pkg::REG_OUTER_LIMIT, {6'd0, lefs_pkg::OUTER_LIMIT_RST});
          write_reg(lefs_pkg::REG_HIGH_CURRENT, lefs_pkg::HIGH_CURRENT_RST);
          write_reg(lefs_pkg::REG_LOW_CURRENT, lefs_pkg::LOW_CURRENT_RST);
        end
        default: begin
          write_reg(lefs_pkg::REG_INNER_LIMIT, 8'($urandom));
          write_reg(lefs_pkg::REG_OUTER_LIMIT, 8'($urandom));
          write_reg(lefs_pkg::REG_HIGH_CURRENT, 8'($urandom));
          write_reg(lefs_pkg::REG_LOW_CURRENT, 8'($urandom));
        end
      endcase
      calm_phase = (phase_no > 3) && ($urandom_range(0, 99) < 25);
      if (phase_no == 3) hold_req = 1'b1;
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS) begin
        if ($urandom_range(0, 99) < 85) run_sequence();
        else repeat ($urandom_range(1, 5)) push_beat(noise_beat());
      end
      phase_no++;
    end

    // Drain and finish
    in_bus.valid = 1'b0;
    drain = 0;
    while (ledger.awaited_results.size() != 0 && drain < 20000) begin
      @(negedge clk);
      drain++;
    end
    repeat (8) @(negedge clk);
    if (ledger.awaited_results.size() != 0) begin
      $display("%0t: %0d result beats expected, actual none", $time,
               ledger.awaited_results.size());
      ledger.errors++;
    end
    if (ledger.errors == 0) begin
      $display("leg_extend_follow_sequencer: match");
    end else begin
      $display("leg_extend_follow_sequencer: mismatch");
    end
    $finish;
  end

endmodule
